// File: design/p2sfla_pkg.sv
package p2sfla_pkg;

	localparam int MIN_CLASS_LOG   = 3;
	localparam int MAX_CLASS_LOG   = 10;
	localparam int ARENA_BYTES_LOG = 16;

	localparam int NCLASS     = MAX_CLASS_LOG - MIN_CLASS_LOG + 1;
	localparam int CLS_W      = (NCLASS > 1) ? $clog2(NCLASS) : 1;
	localparam int IDX_W      = ARENA_BYTES_LOG - MIN_CLASS_LOG;
	localparam int LINK_W     = IDX_W + 1;
	localparam int LINK_DEPTH = 1 << IDX_W;
	localparam int TOP_W      = ARENA_BYTES_LOG + 1;
	localparam int ADDR_W     = 16;
	localparam int SIZE_W     = 16;
	localparam int FUNC_W     = 2;
	localparam int STAT_W     = 2;
	localparam int MAXSZ_W    = 11;

	localparam logic [MAXSZ_W-1:0] MAX_SIZE_RST = 11'd1024;

	localparam logic [FUNC_W-1:0] FN_GET     = 2'd0;
	localparam logic [FUNC_W-1:0] FN_PUT     = 2'd1;
	localparam logic [FUNC_W-1:0] FN_DESTROY = 2'd2;

	localparam logic [STAT_W-1:0] RS_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] RS_OVERSIZE  = 2'd1;
	localparam logic [STAT_W-1:0] RS_EXHAUSTED = 2'd2;

	typedef logic [CLS_W-1:0]  cls_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [LINK_W-1:0] link_t;

	typedef struct packed {
		logic              latch_in;
		logic              do_put;
		logic              do_read;
		logic              do_pop;
		logic              do_carve;
		logic              do_split;
		logic              do_destroy;
		logic              out_load;
		logic [STAT_W-1:0] out_status;
		logic              out_grant;
	} dp_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              oversize;
		logic              found;
		logic              exhausted;
		logic              split_more;
		logic              out_free;
	} dp_stat_t;

	// class offset from MIN_CLASS_LOG, saturating at the top class
	function automatic cls_t class_of(input logic [SIZE_W-1:0] n);
		cls_t c;
		c = cls_t'(NCLASS - 1);
		for (int i = NCLASS - 2; i >= 0; i--) begin
			if (int'(n) <= (1 << (i + MIN_CLASS_LOG)))
				c = cls_t'(i);
		end
		return c;
	endfunction

endpackage

// File: design/p2sfla_if.sv
interface p2sfla_req_if;
	import p2sfla_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [SIZE_W-1:0] request_size;
	logic [ADDR_W-1:0] block_address;

	modport source (output valid, output func, output request_size, output block_address,
		input ready);
	modport sink (input valid, input func, input request_size, input block_address,
		output ready);
endinterface

interface p2sfla_rsp_if;
	import p2sfla_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] granted_address;
	logic [STAT_W-1:0] status;

	modport source (output valid, output granted_address, output status, input ready);
	modport sink (input valid, input granted_address, input status, output ready);
endinterface

// File: design/p2sfla_dp.sv
module p2sfla_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [p2sfla_pkg::MAXSZ_W-1:0] cfg_wdata,
	input  logic [p2sfla_pkg::FUNC_W-1:0]  in_func,
	input  logic [p2sfla_pkg::SIZE_W-1:0]  in_size,
	input  logic [p2sfla_pkg::ADDR_W-1:0]  in_addr,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [p2sfla_pkg::ADDR_W-1:0]  out_addr,
	output logic [p2sfla_pkg::STAT_W-1:0]  out_status,
	input  p2sfla_pkg::dp_cmd_t            cmd,
	output p2sfla_pkg::dp_stat_t           stat
);
	import p2sfla_pkg::*;

	logic [MAXSZ_W-1:0] size_limit_q;
	logic [FUNC_W-1:0]  func_q;
	logic [SIZE_W-1:0]  size_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [TOP_W-1:0]   top_q;
	logic [NCLASS-1:0]  head_valid_q;
	idx_t               head_idx_q [NCLASS];
	idx_t               idx_q;
	cls_t               lvl_q;
	link_t              rdata_q;
	logic               out_valid_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [STAT_W-1:0]  out_status_q;

	link_t link_mem [LINK_DEPTH];

	cls_t             req_k;
	cls_t             chunk_k;
	cls_t             found_k;
	logic             found;
	cls_t             lvl_dn;
	logic [TOP_W-1:0] csize;
	cls_t             push_k;
	idx_t             push_idx;
	logic             push_en;

	always_comb begin
		req_k   = class_of(size_q);
		// class_of saturates, so the cap on the size limit needs no separate min
		chunk_k = class_of(SIZE_W'(size_limit_q));
		found   = 1'b0;
		found_k = '0;
		for (int k = 0; k < NCLASS; k++) begin
			if (!found && head_valid_q[k] && cls_t'(k) >= req_k && cls_t'(k) <= chunk_k) begin
				found   = 1'b1;
				found_k = cls_t'(k);
			end
		end
		csize  = TOP_W'(1) << (TOP_W'(chunk_k) + TOP_W'(MIN_CLASS_LOG));
		lvl_dn = lvl_q - cls_t'(1);
		push_en = cmd.do_put | cmd.do_split;
		if (cmd.do_put) begin
			push_k   = req_k;
			push_idx = idx_t'(addr_q >> MIN_CLASS_LOG);
		end else begin
			push_k   = lvl_dn;
			push_idx = idx_q + (idx_t'(1) << lvl_dn);
		end
	end

	always_comb begin
		stat.func       = func_q;
		stat.oversize   = (int'(size_q) > int'(size_limit_q)) ||
			(int'(size_q) > (1 << MAX_CLASS_LOG));
		stat.found      = found;
		stat.exhausted  = ({1'b0, top_q} + {1'b0, csize}) >
			(TOP_W + 1)'(1 << ARENA_BYTES_LOG);
		stat.split_more = lvl_q > req_k;
		stat.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_limit_q <= MAX_SIZE_RST;
		end else if (cfg_we) begin
			size_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			func_q <= in_func;
			size_q <= in_size;
			addr_q <= in_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
		end else if (cmd.do_destroy) begin
			top_q <= '0;
		end else if (cmd.do_carve) begin
			top_q <= top_q + csize;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= '0;
		end else if (cmd.do_destroy) begin
			head_valid_q <= '0;
		end else if (push_en) begin
			head_valid_q[push_k] <= 1'b1;
		end else if (cmd.do_pop) begin
			head_valid_q[lvl_q] <= rdata_q[IDX_W];
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			head_idx_q[push_k] <= push_idx;
		end else if (cmd.do_pop) begin
			head_idx_q[lvl_q] <= rdata_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_read) begin
			lvl_q <= found_k;
		end else if (cmd.do_carve) begin
			lvl_q <= chunk_k;
		end else if (cmd.do_split) begin
			lvl_q <= lvl_dn;
		end
		if (cmd.do_pop) begin
			idx_q <= head_idx_q[lvl_q];
		end else if (cmd.do_carve) begin
			idx_q <= idx_t'(top_q >> MIN_CLASS_LOG);
		end
	end

	// link store: one write port (push), one registered read port (pop)
	always_ff @(posedge clk) begin
		if (push_en) begin
			link_mem[push_idx] <= {head_valid_q[push_k], head_idx_q[push_k]};
		end
		if (cmd.do_read) begin
			rdata_q <= link_mem[head_idx_q[found_k]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= cmd.out_status;
			out_addr_q   <= cmd.out_grant ? ADDR_W'({idx_q, {MIN_CLASS_LOG{1'b0}}}) : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_addr   = out_addr_q;
	assign out_status = out_status_q;

endmodule

// File: design/p2sfla_ctrl.sv
module p2sfla_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  p2sfla_pkg::dp_stat_t stat,
	output p2sfla_pkg::dp_cmd_t  cmd
);
	import p2sfla_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_POP    = 3'd2;
	localparam logic [2:0] ST_SPLIT  = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]        state_q, state_d;
	logic [STAT_W-1:0] code_q, code_d;
	logic              grant_q, grant_d;

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		grant_d = grant_q;
		cmd     = '0;
		cmd.out_status = code_q;
		cmd.out_grant  = grant_q;
		in_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = ST_DECODE;
				end
			end
			ST_DECODE: begin
				code_d  = RS_DONE;
				grant_d = 1'b0;
				state_d = ST_DONE;
				priority if ((stat.func == FN_GET || stat.func == FN_PUT) && stat.oversize) begin
					code_d = RS_OVERSIZE;
				end else if (stat.func == FN_PUT) begin
					cmd.do_put = 1'b1;
				end else if (stat.func == FN_GET) begin
					if (stat.found) begin
						cmd.do_read = 1'b1;
						grant_d     = 1'b1;
						state_d     = ST_POP;
					end else if (stat.exhausted) begin
						code_d = RS_EXHAUSTED;
					end else begin
						cmd.do_carve = 1'b1;
						grant_d      = 1'b1;
						state_d      = ST_SPLIT;
					end
				end else if (stat.func == FN_DESTROY) begin
					cmd.do_destroy = 1'b1;
				end else begin
					code_d = RS_DONE;
				end
			end
			ST_POP: begin
				cmd.do_pop = 1'b1;
				state_d    = ST_SPLIT;
			end
			ST_SPLIT: begin
				if (stat.split_more) begin
					cmd.do_split = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			code_q  <= RS_DONE;
			grant_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			grant_q <= grant_d;
		end
	end

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.do_put, cmd.do_read, cmd.do_pop, cmd.do_carve, cmd.do_split,
			cmd.do_destroy, cmd.out_load}))
		else $error("more than one datapath update in a cycle");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_DECODE))
		else $error("accepted transaction not decoded next");

	a_pop_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> ($past(state_q) == ST_DECODE && $past(cmd.do_read)))
		else $error("pop without a preceding link read");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !stat.out_free) |=> (state_q == ST_DONE && $stable(code_q)))
		else $error("result lost while output register busy");

endmodule

// File: design/pow2_split_free_list_allocator.sv
// Block allocator over a 64 KiB arena with one LIFO free list per power-of-two class
// (8 bytes up to the chunk size, the next power of two of the size limit, at most 1024).
// One request transaction is taken at a time and gives exactly one response transaction. A
// put, destroy or rejected request passes through the decode and done states; a get also
// passes through the split state, which does one split per step (up to 7 splits), and a pop
// state when it pops an existing free list, because the link store has a registered read
// and each split pushes one half through its write port. The next request is accepted the
// cycle after the response is loaded into the output register. Oversize get or put requests
// (above the size limit or above 1024) return status 1 with no state change; a get that
// would carve past the arena returns status 2. The size limit must only be written while no
// transaction is in progress. The link store is not cleared at reset.
module pow2_split_free_list_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [p2sfla_pkg::MAXSZ_W-1:0] cfg_wdata,
	p2sfla_req_if.sink                     req,
	p2sfla_rsp_if.source                   rsp
);
	import p2sfla_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	p2sfla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	p2sfla_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_func    (req.func),
		.in_size    (req.request_size),
		.in_addr    (req.block_address),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_addr   (rsp.granted_address),
		.out_status (rsp.status),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule

// File: verif/pow2_split_free_list_allocator_tb.sv
`timescale 1ns / 100ps

module pow2_split_free_list_allocator_tb;
	import p2sfla_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 11;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 300;
	localparam int SETTLE_CYCLES  = 16;
	localparam int REPORT_MAX     = 10;

	// spare function code, the block must answer it with a plain done
	localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [STAT_W-1:0] st;
	} grant_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
	} block_t;

	typedef struct {
		bit                is_cfg;
		logic [FUNC_W-1:0] fn;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] addr;
		bit                typed;
		logic [ADDR_W-1:0] t_addr;
		logic [STAT_W-1:0] t_st;
	} step_t;

	typedef struct {
		logic [MAXSZ_W-1:0] size_limit;
		bit                 rnd_max;
		int                 items;
		int                 get_pct;
		int                 big_pct;
		int                 send_idle;
		int                 recv_idle;
	} stage_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [MAXSZ_W-1:0]  cfg_wdata;

	p2sfla_req_if req_ch ();
	p2sfla_rsp_if rsp_ch ();

	pow2_split_free_list_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// directed rows; on a config row the size field carries the register value
	step_t plan [26] = '{
		'{1'b0, FN_GET,     16'd8,     16'h0000, 1'b1, 16'h0000, RS_DONE},
		'{1'b0, FN_GET,     16'd0,     16'h0000, 1'b0, 16'h0000, RS_DONE},
		'{1'b0, FN_GET,     16'd1024,  16'hFFFF, 1'b0, 16'h0000, RS_DONE},
		'{1'b0, FN_GET,     16'd1025,  16'hFFFF, 1'b1, 16'h0000, RS_OVERSIZE},
		'{1'b0, FN_GET,     16'hFFFF,  16'h0000, 1'b1, 16'h0000, RS_OVERSIZE},
		'{1'b0, FN_PUT,     16'hFFFF,  16'hFFFF, 1'b1, 16'h0000, RS_OVERSIZE},
		'{1'b0, FN_PUT,     16'd8,     16'h0000, 1'b1, 16'h0000, RS_DONE},
		'{1'b0, FN_PUT,     16'd3,     16'hFFFF, 1'b1, 16'h0000, RS_DONE},
		'{1'b0, FN_GET,     16'd1,     16'h0000, 1'b0, 16'h0000, RS_DONE},
		'{1'b0, FN_GET,     16'd8,     16'h0000, 1'b0, 16'h0000, RS_DONE},
		'{1'b0, FN_SPARE,   16'hFFFF,  16'hFFFF, 1'b1, 16'h0000, RS_DONE},
		'{1'b0, FN_PUT,     16'd1024,  16'h0400, 1'b1, 16'h0000, RS_DONE},
		'{1'b0, FN_PUT,     16'd1024,  16'h0400, 1'b1, 16'h0000, RS_DONE},
		'{1'b0, FN_GET,     16'd1024,  16'h0000, 1'b0, 16'h0000, RS_DONE},
		'{1'b0, FN_GET,     16'd1024,  16'h0000, 1'b0, 16'h0000, RS_DONE},
		'{1'b0, FN_GET,     16'd512,   16'h0000, 1'b0, 16'h0000, RS_DONE},
		'{1'b0, FN_DESTROY, 16'hFFFF,  16'hFFFF, 1'b1, 16'h0000, RS_DONE},
		'{1'b0, FN_GET,     16'd1024,  16'h0000, 1'b1, 16'h0000, RS_DONE},
		'{1'b0, FN_GET,     16'd16,    16'h0000, 1'b0, 16'h0000, RS_DONE},
		'{1'b0, FN_GET,     16'd1000,  16'h0000, 1'b0, 16'h0000, RS_DONE},
		'{1'b1, FN_GET,     16'd0,     16'h0000, 1'b0, 16'h0000, RS_DONE},
		'{1'b0, FN_GET,     16'd0,     16'h0000, 1'b0, 16'h0000, RS_DONE},
		'{1'b0, FN_GET,     16'd1,     16'h0000, 1'b1, 16'h0000, RS_OVERSIZE},
		'{1'b1, FN_GET,     16'd2047,  16'h0000, 1'b0, 16'h0000, RS_DONE},
		'{1'b0, FN_GET,     16'd1024,  16'h0000, 1'b0, 16'h0000, RS_DONE},
		'{1'b0, FN_DESTROY, 16'h0000,  16'h0000, 1'b1, 16'h0000, RS_DONE}
	};

	stage_t stages [8] = '{
		'{11'd1024, 1'b0, 180, 85, 60, 28, 57},
		'{11'd2047, 1'b0, 130, 55, 10, 28, 57},
		'{11'd700,  1'b0, 130, 55, 20, 28, 57},
		'{11'd8,    1'b0, 100, 55,  0, 57, 28},
		'{11'd0,    1'b0,  60, 55,  0, 57, 28},
		'{11'd64,   1'b0, 110, 60, 30, 57, 28},
		'{11'd1,    1'b0,  60, 55,  0,  0,  0},
		'{11'd0,    1'b1, 100, 60, 30,  0,  0}
	};

	// allocator state as predicted
	logic [MAXSZ_W-1:0] max_reg = MAX_SIZE_RST;
	bit                 free_head_ok [NCLASS];
	idx_t               free_head [NCLASS];
	bit                 next_ok [LINK_DEPTH];
	idx_t               next_blk [LINK_DEPTH];
	int unsigned        bump_ptr;

	grant_t pending_grants [$];
	block_t live_blocks [$];

	int send_idle_pct = 28;
	int recv_idle_pct = 57;
	bit hold_rsp;
	int n_req, n_rsp, n_bad, n_cfg;
	int n_grant, n_over, n_exh, n_put, n_wipe;

	function automatic int unsigned eff_limit();
		return (max_reg < (1 << MAX_CLASS_LOG)) ? max_reg : (1 << MAX_CLASS_LOG);
	endfunction

	// log2 of the class serving n bytes
	function automatic int unsigned size_log(input int unsigned n);
		int unsigned lg;
		lg = MIN_CLASS_LOG;
		while (lg < MAX_CLASS_LOG && (1 << lg) < n)
			lg++;
		return lg;
	endfunction

	function automatic void free_push(input int unsigned lg, input int unsigned blk);
		int unsigned k;
		int unsigned b;
		k = lg - MIN_CLASS_LOG;
		b = blk % LINK_DEPTH;
		next_ok[b] = free_head_ok[k];
		next_blk[b] = free_head[k];
		free_head_ok[k] = 1'b1;
		free_head[k] = idx_t'(b);
	endfunction

	task automatic allocate_step(input logic [FUNC_W-1:0] fn, input logic [SIZE_W-1:0] sz,
			input logic [ADDR_W-1:0] ad, output logic [ADDR_W-1:0] g,
			output logic [STAT_W-1:0] st);
		int unsigned eff, top_lg, want, lvl, blk, k;
		bit hit;
		eff = eff_limit();
		top_lg = size_log(eff);
		g = '0;
		st = RS_DONE;
		hit = 1'b0;
		blk = 0;
		if (fn == FN_GET || fn == FN_PUT) begin
			if (sz > eff) begin
				st = RS_OVERSIZE;
				n_over++;
			end else if (fn == FN_PUT) begin
				free_push(size_log(sz), ad >> MIN_CLASS_LOG);
				n_put++;
			end else begin
				want = size_log(sz);
				lvl = want;
				while (!hit && lvl <= top_lg) begin
					k = lvl - MIN_CLASS_LOG;
					if (free_head_ok[k]) begin
						blk = free_head[k];
						free_head_ok[k] = next_ok[blk];
						free_head[k] = next_blk[blk];
						hit = 1'b1;
					end else begin
						lvl++;
					end
				end
				// nothing free at or above the class: carve a fresh chunk
				if (!hit) begin
					if (bump_ptr + (1 << top_lg) > (1 << ARENA_BYTES_LOG)) begin
						st = RS_EXHAUSTED;
						n_exh++;
					end else begin
						blk = (bump_ptr >> MIN_CLASS_LOG) % LINK_DEPTH;
						bump_ptr += 1 << top_lg;
						lvl = top_lg;
						hit = 1'b1;
					end
				end
				if (hit) begin
					while (lvl > want) begin
						lvl--;
						free_push(lvl, blk + (1 << (lvl - MIN_CLASS_LOG)));
					end
					g = ADDR_W'(blk << MIN_CLASS_LOG);
					n_grant++;
				end
			end
		end else if (fn == FN_DESTROY) begin
			for (int c = 0; c < NCLASS; c++) begin
				free_head_ok[c] = 1'b0;
				free_head[c] = '0;
			end
			bump_ptr = 0;
			n_wipe++;
		end
	endtask

	function automatic logic [SIZE_W-1:0] pick_size(input int big_pct);
		int unsigned eff, lo;
		int r;
		eff = eff_limit();
		lo = eff / 2 + 1;
		if (lo > eff)
			lo = eff;
		r = $urandom_range(99);
		if (r < big_pct)
			return SIZE_W'($urandom_range(eff, lo));
		r = $urandom_range(99);
		if (r < 40)
			return SIZE_W'($urandom_range(eff, 0));
		if (r < 65)
			return SIZE_W'($urandom_range((eff < 64) ? eff : 64, 0));
		if (r < 85)
			return SIZE_W'(1 << $urandom_range(MAX_CLASS_LOG, 0));
		if (r < 93)
			return SIZE_W'(eff + 1 + $urandom_range(7));
		return SIZE_W'($urandom);
	endfunction

	task automatic note_fault(input string msg);
		n_bad++;
		if (n_bad <= REPORT_MAX)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic offer(input logic [FUNC_W-1:0] fn, input logic [SIZE_W-1:0] sz,
			input logic [ADDR_W-1:0] ad, input bit typed, input logic [ADDR_W-1:0] t_addr,
			input logic [STAT_W-1:0] t_st);
		int gap;
		logic [ADDR_W-1:0] g;
		logic [STAT_W-1:0] st;
		grant_t e;
		block_t b;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.func          <= fn;
		req_ch.request_size  <= sz;
		req_ch.block_address <= ad;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		allocate_step(fn, sz, ad, g, st);
		if (typed) begin
			e.addr = t_addr;
			e.st = t_st;
		end else begin
			e.addr = g;
			e.st = st;
		end
		pending_grants.insert(pending_grants.size(), e);
		if (fn == FN_GET && st == RS_DONE) begin
			b.addr = g;
			b.size = sz;
			live_blocks.insert(live_blocks.size(), b);
		end
		if (fn == FN_DESTROY)
			live_blocks.delete();
		n_req++;
	endtask

	// stop offering, let every response land, then give the block time to go idle
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max(input logic [MAXSZ_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		max_reg = v;
		n_cfg++;
	endtask

	task automatic check_response();
		grant_t e;
		if (pending_grants.size() == 0) begin
			note_fault($sformatf("response with nothing pending: granted_address %h status %0d",
				rsp_ch.granted_address, rsp_ch.status));
		end else begin
			e = pending_grants.pop_front();
			if (rsp_ch.granted_address !== e.addr)
				note_fault($sformatf("response %0d granted_address: expected %h, got %h",
					n_rsp, e.addr, rsp_ch.granted_address));
			if (rsp_ch.status !== e.st)
				note_fault($sformatf("response %0d status: expected %0d, got %0d",
					n_rsp, e.st, rsp_ch.status));
		end
		n_rsp++;
	endtask

	// response side
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				check_response();
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
					(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transaction for %0d cycles, %0d responses outstanding",
			WATCHDOG_LIMIT, pending_grants.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic [FUNC_W-1:0] fn;
		logic [SIZE_W-1:0] sz;
		logic [ADDR_W-1:0] ad;
		int r, pick;
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_wdata            <= '0;
		req_ch.valid         <= 1'b0;
		req_ch.func          <= '0;
		req_ch.request_size  <= '0;
		req_ch.block_address <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_max(plan[i].size[MAXSZ_W-1:0]);
			end else begin
				offer(plan[i].fn, plan[i].size, plan[i].addr, plan[i].typed,
					plan[i].t_addr, plan[i].t_st);
			end
		end

		foreach (stages[s]) begin
			settle();
			send_idle_pct = stages[s].send_idle;
			recv_idle_pct = stages[s].recv_idle;
			if (stages[s].rnd_max)
				write_max(MAXSZ_W'($urandom_range(2047, 2)));
			else
				write_max(stages[s].size_limit);
			// one long response stall while requests keep coming
			if (s == 1)
				hold_rsp = 1'b1;
			for (int i = 0; i < stages[s].items; i++) begin
				r = $urandom_range(999);
				sz = pick_size(stages[s].big_pct);
				ad = ADDR_W'($urandom);
				if (r < 5) begin
					fn = FN_DESTROY;
				end else if (r < 25) begin
					fn = FN_SPARE;
				end else if (r < 25 + 10 * stages[s].get_pct) begin
					fn = FN_GET;
				end else begin
					fn = FN_PUT;
					// mostly hand back a block that is really out, else a stray address
					if (live_blocks.size() != 0 && $urandom_range(99) < 80) begin
						pick = $urandom_range(live_blocks.size() - 1);
						ad = live_blocks[pick].addr;
						sz = live_blocks[pick].size;
						live_blocks.delete(pick);
					end
				end
				offer(fn, sz, ad, 1'b0, '0, RS_DONE);
			end
		end
		settle();

		$display("Ran %0d requests over %0d size-limit settings: %0d grants, %0d puts, %0d destroys.",
			n_req, n_cfg, n_grant, n_put, n_wipe);
		$display("Oversize rejects %0d, arena exhausted %0d, mismatches %0d.",
			n_over, n_exh, n_bad);
		if (n_bad == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
